### hdl/sru_pkg.sv
// shared types and constants for the x86 shift and rotate unit
`timescale 1ns / 1ps

package sru_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_SHL = 3'd0,
    OP_SHR = 3'd1,
    OP_SAR = 3'd2,
    OP_ROL = 3'd3,
    OP_ROR = 3'd4,
    OP_RCL = 3'd5,
    OP_RCR = 3'd6
  } sru_op_e;

  // operand size codes
  typedef enum logic [1:0] {
    WS_8  = 2'd0,
    WS_16 = 2'd1,
    WS_32 = 2'd2
  } sru_width_e;

  localparam logic [4:0]  CountMask = 5'h1F;
  localparam logic [31:0] Mask8     = 32'h0000_00ff;
  localparam logic [31:0] Mask16    = 32'h0000_ffff;
  localparam logic [31:0] Mask32    = 32'hffff_ffff;

  // input item
  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  width_sel;
    logic [7:0]  shift_count;
    logic [31:0] operand_value;
    logic        carry_in;
  } sru_item_t;

  // result item
  typedef struct packed {
    logic [31:0] result_value;
    logic        flags_written;
    logic        carry_out;
    logic        overflow_out;
    logic        parity_out;
    logic        zero_out;
    logic        sign_out;
  } sru_result_t;

endpackage

### hdl/sru_datapath.sv
// combinational barrel shifter, rotator and flag logic
`timescale 1ns / 1ps

module sru_datapath import sru_pkg::*; (
  input  sru_item_t   item_i,
  output sru_result_t result_o
);

  logic [4:0]  cnt;
  logic [31:0] mask;
  logic [31:0] x;
  logic        cin;
  logic        msb_x;

  logic [63:0] shl64;
  logic [31:0] shr_res;
  logic [63:0] ext64;
  logic [63:0] sar64;
  logic [31:0] shl_res;
  logic        shl_cf;
  logic [31:0] sar_res;
  logic        shr_cf;
  logic        sar_cf;

  logic [15:0] rol8, ror8;
  logic [31:0] rol16, ror16;
  logic [63:0] rol32, ror32;
  logic [31:0] rol_res, ror_res;

  logic [4:0]  r9, r17;
  logic [8:0]  v9;
  logic [16:0] v17;
  logic [32:0] v33;
  logic [17:0] rcl9, rcr9;
  logic [33:0] rcl17, rcr17;
  logic [65:0] rcl33, rcr33;
  logic [32:0] rcl_rot, rcr_rot;

  sru_result_t res;

  // top bit of a value at the selected width
  function automatic logic top_bit(input logic [31:0] v, input logic [1:0] ws);
    logic b;
    unique case (ws)
      WS_8:    b = v[7];
      WS_16:   b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

  // second bit from the top at the selected width
  function automatic logic next_bit(input logic [31:0] v, input logic [1:0] ws);
    logic b;
    unique case (ws)
      WS_8:    b = v[6];
      WS_16:   b = v[14];
      default: b = v[30];
    endcase
    return b;
  endfunction

  // operand masking and count
  always_comb begin
    unique case (item_i.width_sel)
      WS_8:    mask = Mask8;
      WS_16:   mask = Mask16;
      default: mask = Mask32;
    endcase
  end

  assign cnt   = item_i.shift_count[4:0] & CountMask;
  assign x     = item_i.operand_value & mask;
  assign cin   = item_i.carry_in;
  assign msb_x = top_bit(x, item_i.width_sel);

  // logical and arithmetic shifts
  assign shl64   = {32'd0, x} << cnt;
  assign shl_res = shl64[31:0] & mask;
  assign shr_res = x >> cnt;
  assign shr_cf  = x[cnt - 5'd1];
  assign ext64   = msb_x ? ({32'hffff_ffff, x} | {32'hffff_ffff, ~mask}) : {32'd0, x};
  assign sar64   = ext64 >> cnt;
  assign sar_res = sar64[31:0] & mask;
  assign sar_cf  = ext64[cnt - 5'd1];

  always_comb begin
    unique case (item_i.width_sel)
      WS_8:    shl_cf = shl64[8];
      WS_16:   shl_cf = shl64[16];
      default: shl_cf = shl64[32];
    endcase
  end

  // plain rotates, count modulo the width
  assign rol8  = {x[7:0], x[7:0]} << cnt[2:0];
  assign ror8  = {x[7:0], x[7:0]} >> cnt[2:0];
  assign rol16 = {x[15:0], x[15:0]} << cnt[3:0];
  assign ror16 = {x[15:0], x[15:0]} >> cnt[3:0];
  assign rol32 = {x, x} << cnt;
  assign ror32 = {x, x} >> cnt;

  // rotate-through-carry counts, modulo width plus one
  always_comb begin
    if (cnt >= 5'd27) begin
      r9 = cnt - 5'd27;
    end else if (cnt >= 5'd18) begin
      r9 = cnt - 5'd18;
    end else if (cnt >= 5'd9) begin
      r9 = cnt - 5'd9;
    end else begin
      r9 = cnt;
    end
    r17 = (cnt >= 5'd17) ? cnt - 5'd17 : cnt;
  end

  assign v9    = {cin, x[7:0]};
  assign v17   = {cin, x[15:0]};
  assign v33   = {cin, x};
  assign rcl9  = {v9, v9} << r9;
  assign rcr9  = {v9, v9} >> r9;
  assign rcl17 = {v17, v17} << r17;
  assign rcr17 = {v17, v17} >> r17;
  assign rcl33 = {v33, v33} << cnt;
  assign rcr33 = {v33, v33} >> cnt;

  // width select for the rotators; carry sits just above the width
  always_comb begin
    unique case (item_i.width_sel)
      WS_8: begin
        rol_res = {24'd0, rol8[15:8]};
        ror_res = {24'd0, ror8[7:0]};
        rcl_rot = {24'd0, rcl9[17:9]};
        rcr_rot = {24'd0, rcr9[8:0]};
      end
      WS_16: begin
        rol_res = {16'd0, rol16[31:16]};
        ror_res = {16'd0, ror16[15:0]};
        rcl_rot = {16'd0, rcl17[33:17]};
        rcr_rot = {16'd0, rcr17[16:0]};
      end
      default: begin
        rol_res = rol32[63:32];
        ror_res = ror32[31:0];
        rcl_rot = rcl33[65:33];
        rcr_rot = rcr33[32:0];
      end
    endcase
  end

  // per-operation result and flags
  always_comb begin
    res               = '0;
    res.result_value  = x;
    if (cnt != 5'd0) begin
      unique case (item_i.func)
        OP_SHL: begin
          res.result_value = shl_res;
          res.carry_out    = shl_cf;
          res.overflow_out = top_bit(shl_res, item_i.width_sel) ^ shl_cf;
          res.parity_out   = ~^shl_res[7:0];
          res.zero_out     = (shl_res == 32'd0);
          res.sign_out     = top_bit(shl_res, item_i.width_sel);
          res.flags_written = 1'b1;
        end
        OP_SHR: begin
          res.result_value = shr_res;
          res.carry_out    = shr_cf;
          res.overflow_out = msb_x;
          res.parity_out   = ~^shr_res[7:0];
          res.zero_out     = (shr_res == 32'd0);
          res.sign_out     = top_bit(shr_res, item_i.width_sel);
          res.flags_written = 1'b1;
        end
        OP_SAR: begin
          res.result_value = sar_res;
          res.carry_out    = sar_cf;
          res.parity_out   = ~^sar_res[7:0];
          res.zero_out     = (sar_res == 32'd0);
          res.sign_out     = top_bit(sar_res, item_i.width_sel);
          res.flags_written = 1'b1;
        end
        OP_ROL: begin
          res.result_value = rol_res;
          res.carry_out    = rol_res[0];
          res.overflow_out = top_bit(rol_res, item_i.width_sel) ^ rol_res[0];
          res.flags_written = 1'b1;
        end
        OP_ROR: begin
          res.result_value = ror_res;
          res.carry_out    = top_bit(ror_res, item_i.width_sel);
          res.overflow_out = top_bit(ror_res, item_i.width_sel)
                             ^ next_bit(ror_res, item_i.width_sel);
          res.flags_written = 1'b1;
        end
        OP_RCL: begin
          res.result_value = rcl_rot[31:0] & mask;
          res.carry_out    = rcl_rot[32] | ((rcl_rot[31:0] & ~mask) != 32'd0);
          res.overflow_out = top_bit(rcl_rot[31:0] & mask, item_i.width_sel)
                             ^ res.carry_out;
          res.flags_written = 1'b1;
        end
        OP_RCR: begin
          res.result_value = rcr_rot[31:0] & mask;
          res.carry_out    = rcr_rot[32] | ((rcr_rot[31:0] & ~mask) != 32'd0);
          res.overflow_out = msb_x ^ cin;
          res.flags_written = 1'b1;
        end
        default: begin
          res.result_value = x;
        end
      endcase
    end
  end

  assign result_o = res;

endmodule

### hdl/x86_shift_rotate_unit.sv
// An accepted item is held in the input register, passes the combinational
// datapath and is loaded into the result register, shown on result_o with
// done_o high. Throughput: one item per cycle; busy stays low, the receiver
// cannot stall, and the result register loads while the input one is valid.
// Reset: rst_ni low clears the input and result valid bits at once.
`timescale 1ns / 1ps

module x86_shift_rotate_unit import sru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  sru_item_t   item_i,
  output logic        done_o,
  output sru_result_t result_o
);

  logic        in_vld_q;
  logic        in_vld_d;
  sru_item_t   item_q;
  logic        done_q;
  sru_result_t res_d;
  sru_result_t res_q;
  logic        accept;

  // the unit takes an item every cycle
  assign busy     = 1'b0;
  assign accept   = start & ~busy;
  assign in_vld_d = accept;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      done_q   <= in_vld_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  sru_datapath u_datapath (
    .item_i   (item_q),
    .result_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### hdl/sru_checker.sv
// port-level checker for the x86 shift and rotate unit and its bind
`timescale 1ns / 1ps

module sru_checker import sru_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input sru_item_t   item_i,
  input logic        done_o,
  input sru_result_t result_o
);

  // every accepted item is followed by a result with done_o high
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted item gave no result");

  // no result without an earlier accepted item
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  // untouched flags read as zero
  a_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.flags_written) |->
      (!result_o.carry_out && !result_o.overflow_out && !result_o.parity_out
       && !result_o.zero_out && !result_o.sign_out))
    else $error("flags set while not written");

  // zero count never writes flags
  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(item_i.shift_count[4:0], 2) == 5'd0) |-> !result_o.flags_written)
    else $error("flags written on zero count");

  // result is zero above the selected width
  a_width_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |->
      (($past(item_i.width_sel, 2) != WS_8  || result_o.result_value[31:8] == 24'd0) &&
       ($past(item_i.width_sel, 2) != WS_16 || result_o.result_value[31:16] == 16'd0)))
    else $error("result bits set above operand width");

endmodule

bind x86_shift_rotate_unit sru_checker u_sru_checker (.*);
